/* src/wcmm_pkg.sv */
package wcmm_pkg;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_MAX_SAMPLES  = 1024;

    localparam int SAMPLE_W   = 32;
    localparam int PAIR_W     = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 144;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BUFFER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BUFFERS     = 2'd2;

    typedef enum logic [2:0] {
        ST_IN,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT,
        ST_GLOBAL
    } state_t;

endpackage

/* src/windowed_channel_min_max_tracker.sv */
// Samples that do not close a buffer: one per cycle while no configuration write is pending, no result.
// Closing sample: for each channel the history RAM is read once per held buffer, the
// read data is awaited, then the channel result is emitted once the output register is
// free; the global result follows the last channel, and only then is the next sample taken.
// Reset clears all control state and sets the three registers to 1; the history RAM
// is not cleared, an entry is only read after it has been written.
module windowed_channel_min_max_tracker #(
    parameter int MAX_CHANNELS = wcmm_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = wcmm_pkg::DEF_MAX_WINDOW,
    parameter int MAX_SAMPLES  = wcmm_pkg::DEF_MAX_SAMPLES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wcmm_pkg::SAMPLE_W-1:0]   s_tdata,   // sample[31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wcmm_pkg::OUT_DATA_W-1:0] m_tdata,   // channel[3:0], buffer_min[35:4],
                                                       // buffer_max[67:36],
                                                       // window_min[99:68],
                                                       // window_max[131:100],
                                                       // buffers_held[138:132]
    output logic                            m_tuser,   // is_global
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wcmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wcmm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wcmm_pkg::*;

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CC_W   = $clog2(MAX_CHANNELS + 1);
    localparam int SP_W   = $clog2(MAX_SAMPLES + 1);
    localparam int HC_W   = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = SLOT_W + CH_W;

    localparam logic signed [SAMPLE_W-1:0] POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

    state_t state_reg, state_next;

    logic [CC_W-1:0]   cc_reg;
    logic [SP_W-1:0]   spb_reg;
    logic [HC_W-1:0]   win_reg;
    logic [HC_W-1:0]   held_reg;
    logic [SP_W-1:0]   pos_reg;
    logic [CH_W-1:0]   ch_pos_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] newest_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [CH_W-1:0]   ch_scan_reg;
    logic [HC_W-1:0]   k_reg;
    logic              rd_valid_reg;
    logic              rd_first_reg;

    logic signed [SAMPLE_W-1:0] run_min_reg, run_max_reg;
    logic signed [SAMPLE_W-1:0] buf_min_reg, buf_max_reg, win_min_reg, win_max_reg;
    logic signed [SAMPLE_W-1:0] g_bmin_reg, g_bmax_reg, g_wmin_reg, g_wmax_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_global_reg;

    logic signed [SAMPLE_W-1:0] sample, new_min, new_max, rd_min, rd_max;
    logic                       in_fire, chan_end, buf_end, last_ch, scan_done, out_free;
    logic                       cfg_fire;
    logic                       rd_en, wr_en, out_load_ch, out_load_glob;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic [PAIR_W-1:0]          rd_data;
    logic [CH_W+3:0]            ch_ext;
    logic [HC_W+6:0]            held_ext;
    logic signed [SAMPLE_W-1:0] em_bmin, em_bmax, em_wmin, em_wmax;
    logic [4:0]                 cfg_cc;
    logic [6:0]                 cfg_wb;

    assign sample    = s_tdata;
    assign new_min   = (sample < run_min_reg) ? sample : run_min_reg;
    assign new_max   = (sample > run_max_reg) ? sample : run_max_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign chan_end  = (pos_reg == spb_reg - SP_W'(1));
    assign buf_end   = (CC_W'(ch_pos_reg) == cc_reg - CC_W'(1));
    assign last_ch   = (CC_W'(ch_scan_reg) == cc_reg - CC_W'(1));
    assign scan_done = (k_reg == held_reg - HC_W'(1));
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_min    = rd_data[SAMPLE_W-1:0];
    assign rd_max    = rd_data[PAIR_W-1:SAMPLE_W];
    assign rd_addr   = {rd_slot_reg, ch_scan_reg};
    assign wr_addr   = {write_slot_reg, ch_pos_reg};
    assign ch_ext    = {4'b0, ch_scan_reg};
    assign held_ext  = {7'b0, held_reg};
    assign cfg_cc    = cfg_data[4:0];
    assign cfg_wb    = cfg_data[6:0];
    assign cfg_ready = (state_reg == ST_IN);

    // global candidates: first channel seeds them
    assign em_bmin = (ch_scan_reg == '0 || buf_min_reg < g_bmin_reg) ? buf_min_reg : g_bmin_reg;
    assign em_bmax = (ch_scan_reg == '0 || buf_max_reg > g_bmax_reg) ? buf_max_reg : g_bmax_reg;
    assign em_wmin = (ch_scan_reg == '0 || win_min_reg < g_wmin_reg) ? win_min_reg : g_wmin_reg;
    assign em_wmax = (ch_scan_reg == '0 || win_max_reg > g_wmax_reg) ? win_max_reg : g_wmax_reg;

    wcmm_hist_ram #(
        .ADDR_W(ADDR_W)
    ) u_hist (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data({new_max, new_min}),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IN:
            begin
                if (in_fire && chan_end && buf_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_ch ? ST_GLOBAL : ST_SCAN;
                end
            end
            ST_GLOBAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IN;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == ST_IN) && !cfg_valid;
        rd_en         = (state_reg == ST_SCAN);
        wr_en         = in_fire && chan_end;
        out_load_ch   = (state_reg == ST_EMIT) && out_free;
        out_load_glob = (state_reg == ST_GLOBAL) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and sample bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg         <= CC_W'(1);
            spb_reg        <= SP_W'(1);
            win_reg        <= HC_W'(1);
            held_reg       <= '0;
            pos_reg        <= '0;
            ch_pos_reg     <= '0;
            write_slot_reg <= '0;
            newest_reg     <= '0;
            run_min_reg    <= POS_MAX;
            run_max_reg    <= NEG_MAX;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT:
                begin
                    if (cfg_cc == '0)
                        cc_reg <= CC_W'(1);
                    else if (int'(cfg_cc) > MAX_CHANNELS)
                        cc_reg <= CC_W'(MAX_CHANNELS);
                    else
                        cc_reg <= CC_W'(cfg_cc);
                    pos_reg     <= '0;
                    ch_pos_reg  <= '0;
                    run_min_reg <= POS_MAX;
                    run_max_reg <= NEG_MAX;
                    held_reg    <= '0;
                end
                CFG_SAMPLES_PER_BUFFER:
                begin
                    if (cfg_data == '0)
                        spb_reg <= SP_W'(1);
                    else if (int'(cfg_data) > MAX_SAMPLES)
                        spb_reg <= SP_W'(MAX_SAMPLES);
                    else
                        spb_reg <= SP_W'(cfg_data);
                    pos_reg     <= '0;
                    ch_pos_reg  <= '0;
                    run_min_reg <= POS_MAX;
                    run_max_reg <= NEG_MAX;
                end
                CFG_WINDOW_BUFFERS:
                begin
                    if (cfg_wb == '0)
                    begin
                        win_reg <= HC_W'(1);
                        if (held_reg > HC_W'(1))
                            held_reg <= HC_W'(1);
                    end
                    else if (int'(cfg_wb) > MAX_WINDOW)
                    begin
                        win_reg <= HC_W'(MAX_WINDOW);
                        if (held_reg > HC_W'(MAX_WINDOW))
                            held_reg <= HC_W'(MAX_WINDOW);
                    end
                    else
                    begin
                        win_reg <= HC_W'(cfg_wb);
                        if (held_reg > HC_W'(cfg_wb))
                            held_reg <= HC_W'(cfg_wb);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (!chan_end)
            begin
                pos_reg     <= pos_reg + SP_W'(1);
                run_min_reg <= new_min;
                run_max_reg <= new_max;
            end
            else
            begin
                pos_reg     <= '0;
                run_min_reg <= POS_MAX;
                run_max_reg <= NEG_MAX;
                if (!buf_end)
                begin
                    ch_pos_reg <= ch_pos_reg + CH_W'(1);
                end
                else
                begin
                    ch_pos_reg <= '0;
                    newest_reg <= write_slot_reg;
                    if (write_slot_reg == SLOT_W'(MAX_WINDOW - 1))
                        write_slot_reg <= '0;
                    else
                        write_slot_reg <= write_slot_reg + SLOT_W'(1);
                    if (held_reg < win_reg)
                        held_reg <= held_reg + HC_W'(1);
                end
            end
        end
    end

    // window scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_slot_reg  <= '0;
            ch_scan_reg  <= '0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en && (k_reg == '0);
            if (in_fire && chan_end && buf_end)
            begin
                rd_slot_reg <= write_slot_reg;
                ch_scan_reg <= '0;
                k_reg       <= '0;
            end
            else if (rd_en)
            begin
                k_reg <= k_reg + HC_W'(1);
                if (rd_slot_reg == '0)
                    rd_slot_reg <= SLOT_W'(MAX_WINDOW - 1);
                else
                    rd_slot_reg <= rd_slot_reg - SLOT_W'(1);
            end
            else if (out_load_ch && !last_ch)
            begin
                ch_scan_reg <= ch_scan_reg + CH_W'(1);
                rd_slot_reg <= newest_reg;
                k_reg       <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            if (rd_first_reg)
            begin
                buf_min_reg <= rd_min;
                buf_max_reg <= rd_max;
                win_min_reg <= rd_min;
                win_max_reg <= rd_max;
            end
            else
            begin
                if (rd_min < win_min_reg)
                    win_min_reg <= rd_min;
                if (rd_max > win_max_reg)
                    win_max_reg <= rd_max;
            end
        end
        if (out_load_ch)
        begin
            g_bmin_reg <= em_bmin;
            g_bmax_reg <= em_bmax;
            g_wmin_reg <= em_wmin;
            g_wmax_reg <= em_wmax;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ch || out_load_glob)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_ch)
        begin
            out_data_reg   <= {5'b0, held_ext[6:0], win_max_reg, win_min_reg,
                               buf_max_reg, buf_min_reg, ch_ext[3:0]};
            out_global_reg <= 1'b0;
        end
        else if (out_load_glob)
        begin
            out_data_reg   <= {5'b0, held_ext[6:0], g_wmax_reg, g_wmin_reg,
                               g_bmax_reg, g_bmin_reg, 4'b0};
            out_global_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_global_reg;
    assign m_tlast  = out_global_reg;

`ifndef SYNTH
    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IN |-> held_reg != '0 && held_reg <= win_reg)
        else $error("window count out of range during scan");

    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg) == ST_SCAN)
        else $error("RAM read data without a scan request");

    a_positions: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < spb_reg && CC_W'(ch_pos_reg) < cc_reg)
        else $error("sample or channel position past its bound");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load_ch || out_load_glob) |=> m_tvalid && m_tuser == $past(out_load_glob))
        else $error("result load lost or mislabeled");
`endif

endmodule

/* src/wcmm_hist_ram.sv */
module wcmm_hist_ram #(
    parameter int ADDR_W = 10
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [wcmm_pkg::PAIR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [wcmm_pkg::PAIR_W-1:0] rd_data
);
    import wcmm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [PAIR_W-1:0] mem [DEPTH];
    logic [PAIR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* dv/tb_windowed_channel_min_max_tracker.sv */
`timescale 1ns / 100ps
module tb_windowed_channel_min_max_tracker;
    import wcmm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic [3:0]         channel;
        logic               is_global;
        logic signed [31:0] buf_lo;
        logic signed [31:0] buf_hi;
        logic signed [31:0] win_lo;
        logic signed [31:0] win_hi;
        logic [6:0]         held;
        logic               last;
    } tracker_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    windowed_channel_min_max_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tracker_result_t pending_results[$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int mismatches;
    int samples_sent;
    int buffers_closed;
    int results_seen;
    int reg_writes;

    // model state
    int unsigned        chan_count;
    int unsigned        buf_len;
    int unsigned        win_len;
    logic signed [31:0] run_lo;
    logic signed [31:0] run_hi;
    int unsigned        sample_pos;
    int unsigned        chan_pos;
    int unsigned        slot;
    int unsigned        held;
    logic signed [31:0] hist_lo [DEF_MAX_WINDOW][DEF_MAX_CHANNELS];
    logic signed [31:0] hist_hi [DEF_MAX_WINDOW][DEF_MAX_CHANNELS];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_windowed_channel_min_max_tracker NOT OK");
        $finish;
    end

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void restart_buffer();
        run_lo = 32'sh7FFF_FFFF;
        run_hi = 32'sh8000_0000;
        sample_pos = 0;
        chan_pos = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CHANNEL_COUNT:
            begin
                chan_count = clamp_reg(data[4:0], DEF_MAX_CHANNELS);
                restart_buffer();
                held = 0;
            end
            CFG_SAMPLES_PER_BUFFER:
            begin
                buf_len = clamp_reg(data, DEF_MAX_SAMPLES);
                restart_buffer();
            end
            CFG_WINDOW_BUFFERS:
            begin
                win_len = clamp_reg(data[6:0], DEF_MAX_WINDOW);
                if (held > win_len)
                begin
                    held = win_len;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void track_sample(logic signed [31:0] s);
        tracker_result_t    r;
        logic signed [31:0] g_blo;
        logic signed [31:0] g_bhi;
        logic signed [31:0] g_wlo;
        logic signed [31:0] g_whi;
        logic signed [31:0] wlo;
        logic signed [31:0] whi;
        int unsigned        newest;
        int unsigned        sl;

        if (s < run_lo)
        begin
            run_lo = s;
        end
        if (s > run_hi)
        begin
            run_hi = s;
        end
        sample_pos++;
        if (sample_pos < buf_len)
        begin
            return;
        end
        hist_lo[slot][chan_pos] = run_lo;
        hist_hi[slot][chan_pos] = run_hi;
        run_lo = 32'sh7FFF_FFFF;
        run_hi = 32'sh8000_0000;
        sample_pos = 0;
        chan_pos++;
        if (chan_pos < chan_count)
        begin
            return;
        end

        chan_pos = 0;
        newest = slot;
        slot = (slot + 1) % DEF_MAX_WINDOW;
        if (held < win_len)
        begin
            held++;
        end
        buffers_closed++;

        g_blo = 32'sh7FFF_FFFF;
        g_bhi = 32'sh8000_0000;
        g_wlo = 32'sh7FFF_FFFF;
        g_whi = 32'sh8000_0000;
        for (int unsigned c = 0; c < chan_count; c++)
        begin
            wlo = 32'sh7FFF_FFFF;
            whi = 32'sh8000_0000;
            for (int unsigned k = 0; k < held; k++)
            begin
                sl = (newest + DEF_MAX_WINDOW - k) % DEF_MAX_WINDOW;
                if (hist_lo[sl][c] < wlo)
                begin
                    wlo = hist_lo[sl][c];
                end
                if (hist_hi[sl][c] > whi)
                begin
                    whi = hist_hi[sl][c];
                end
            end
            r.channel   = c[3:0];
            r.is_global = 1'b0;
            r.buf_lo    = hist_lo[newest][c];
            r.buf_hi    = hist_hi[newest][c];
            r.win_lo    = wlo;
            r.win_hi    = whi;
            r.held      = held[6:0];
            r.last      = 1'b0;
            pending_results = {pending_results, r};
            if (r.buf_lo < g_blo)
            begin
                g_blo = r.buf_lo;
            end
            if (r.buf_hi > g_bhi)
            begin
                g_bhi = r.buf_hi;
            end
            if (wlo < g_wlo)
            begin
                g_wlo = wlo;
            end
            if (whi > g_whi)
            begin
                g_whi = whi;
            end
        end
        r.channel   = 4'd0;
        r.is_global = 1'b1;
        r.buf_lo    = g_blo;
        r.buf_hi    = g_bhi;
        r.win_lo    = g_wlo;
        r.win_hi    = g_whi;
        r.held      = held[6:0];
        r.last      = 1'b1;
        pending_results = {pending_results, r};
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tracker_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: channel %0d global %0b", m_tdata[3:0], m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("channel", want.channel, m_tdata[3:0]);
                check_field("is_global", want.is_global, m_tuser);
                check_field("buffer_min", want.buf_lo, m_tdata[35:4]);
                check_field("buffer_max", want.buf_hi, m_tdata[67:36]);
                check_field("window_min", want.win_lo, m_tdata[99:68]);
                check_field("window_max", want.win_hi, m_tdata[131:100]);
                check_field("buffers_held", want.held, m_tdata[138:132]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // output side: random stalls plus an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_sample(logic signed [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = v;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        track_sample(v);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_register(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3: return -32'sh1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0);
        send_sample(-32'sh1);
        send_sample(32'sh0001_0000);
    endtask

    task automatic test_register_limits();
        write_register(CFG_CHANNEL_COUNT, 11'd0);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd0);
        write_register(CFG_WINDOW_BUFFERS, 11'd0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        // 0x7FF masks to 31, saturates to 16 channels
        write_register(CFG_CHANNEL_COUNT, 11'h7FF);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd1);
        write_register(CFG_WINDOW_BUFFERS, 11'd2);
        for (int i = 0; i < 16; i++)
        begin
            send_sample(i[0] ? 32'sh7FFF_FFFF - i : 32'sh8000_0000 + i);
        end
        // bit 5 set, masks to zero, counts as one channel
        write_register(CFG_CHANNEL_COUNT, 11'h020);
    endtask

    task automatic test_ignored_index();
        write_register(CFG_CHANNEL_COUNT, 11'd2);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd3);
        repeat (4) send_sample(pick_sample());
        write_register(CFG_UNUSED, 11'h7FF);
        repeat (2) send_sample(pick_sample());
    endtask

    task automatic test_dropped_buffer();
        repeat (3) send_sample(32'sh8000_0000);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd3);
        repeat (6) send_sample(pick_sample());
        repeat (2) send_sample(32'sh7FFF_FFFF);
        write_register(CFG_CHANNEL_COUNT, 11'd2);
        repeat (6) send_sample(pick_sample());
    endtask

    task automatic test_window_fill_shrink();
        write_register(CFG_CHANNEL_COUNT, 11'd1);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd1);
        write_register(CFG_WINDOW_BUFFERS, 11'h7F);
        repeat (70) send_sample(pick_sample());
        write_register(CFG_WINDOW_BUFFERS, 11'd3);
        repeat (4) send_sample(pick_sample());
        write_register(CFG_WINDOW_BUFFERS, 11'd64);
        repeat (10) send_sample(pick_sample());
    endtask

    // 0x7FF saturates to 1024 samples; the open buffer must not close early
    task automatic test_largest_buffer();
        write_register(CFG_CHANNEL_COUNT, 11'd1);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'h7FF);
        write_register(CFG_WINDOW_BUFFERS, 11'd2);
        repeat (24) send_sample($urandom);
    endtask

    task automatic test_output_hold_off();
        write_register(CFG_CHANNEL_COUNT, 11'd4);
        write_register(CFG_SAMPLES_PER_BUFFER, 11'd2);
        write_register(CFG_WINDOW_BUFFERS, 11'd8);
        @(posedge clk);
        hold_left = HOLD_OFF_CYCLES;
        @(negedge clk);
        repeat (48) send_sample(pick_sample());
    endtask

    task automatic test_random_traffic(int idle, int stall, int n_samples);
        int unsigned v;
        int unsigned n;
        int          sent;

        settle();
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_samples)
        begin
            if ($urandom_range(3) == 0)
            begin
                v = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
                write_register(CFG_CHANNEL_COUNT, {6'($urandom), 5'(v)});
            end
            if ($urandom_range(2) == 0)
            begin
                v = ($urandom_range(5) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 3);
                write_register(CFG_SAMPLES_PER_BUFFER, 11'(v));
            end
            if ($urandom_range(2) == 0)
            begin
                v = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
                write_register(CFG_WINDOW_BUFFERS, {4'($urandom), 7'(v)});
            end
            if ($urandom_range(9) == 0)
            begin
                write_register(CFG_UNUSED, 11'($urandom));
            end
            n = $urandom_range(1, 3) * chan_count * buf_len;
            if ($urandom_range(3) == 0)
            begin
                n += $urandom_range(1, chan_count * buf_len);
            end
            repeat (n) send_sample(pick_sample());
            sent += n;
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHANNEL_COUNT;
        cfg_data = '0;
        rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        mismatches = 0;
        samples_sent = 0;
        buffers_closed = 0;
        results_seen = 0;
        reg_writes = 0;
        chan_count = 1;
        buf_len = 1;
        win_len = 1;
        slot = 0;
        held = 0;
        restart_buffer();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_limits();
        test_ignored_index();
        test_dropped_buffer();
        test_window_fill_shrink();
        test_largest_buffer();
        test_output_hold_off();
        test_random_traffic(0, 0, 50);
        test_random_traffic(64, 0, 50);
        test_random_traffic(0, 64, 50);
        test_random_traffic(30, 30, 50);

        settle();
        repeat (20) @(negedge clk);
        $display("Covered %0d samples, %0d buffers closed, %0d results checked, %0d reg writes",
                 samples_sent, buffers_closed, results_seen, reg_writes);
        $display("Clamps, dropped buffers, ring wrap and window resize, long hold-off, 4 mixes");
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("tb_windowed_channel_min_max_tracker OK");
        end
        else
        begin
            $display("tb_windowed_channel_min_max_tracker NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/wcmm_pkg.sv
src/wcmm_hist_ram.sv
src/windowed_channel_min_max_tracker.sv
dv/tb_windowed_channel_min_max_tracker.sv
